@@ src/ple_pkg.sv @@
`default_nettype none
// ============================================================================
// ple_pkg
// Shared types and constants for the positional list engine: operation and
// status codes, controller states, and the command/status bundles that run
// between the controller and the datapath.
// ============================================================================
package ple_pkg;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 3;
    // Position arithmetic is done one bit wider than a position so that
    // count + 1 never wraps.
    localparam int CMP_W    = 8;
    // Width of the element count as seen outside the datapath (capacity <= 127).
    localparam int COUNT_W  = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_DUMP      = 3'd7
    } ple_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } ple_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_REPORT
    } ple_state_t;

    typedef struct packed {
        logic load;
        logic apply;
        logic scan_clr;
        logic scan_step;
        logic emit_elem;
        logic emit_search;
    } ple_cmd_t;

    typedef struct packed {
        logic               out_free;
        logic               scan_needed;
        logic               scan_last;
        logic               is_dump;
        logic [COUNT_W-1:0] count;
    } ple_dp_status_t;

endpackage
`default_nettype wire

@@ src/positional_list_engine.sv @@
`default_nettype none
// ============================================================================
// positional_list_engine
// Ordered list of signed 32-bit values with positional insert and delete,
// search, and in-order read-out.
// ============================================================================
// Usage:
// The input channel (in_valid/in_ready) carries one operation per transfer:
// opcode, item_value and item_position. The output channel (out_valid/
// out_ready) returns status, found_position, out_value and last. Every
// operation yields exactly one result with last set, except a dump of a
// non-empty list, which yields one result per element, front first, with
// last set on the final one.
// Inserts and deletes complete in a single decide step: the result is
// written into the output register from the decide state that follows the
// input transfer, once that register is free, and no new item is taken before
// that. Search and dump rotate the cell row once around, one cell per cycle
// (a dump only while the output register is free): a search writes its result
// after the turn, a dump writes each element as the row turns, and the next
// item is taken once the final result has been written.
// The output register decouples the two sides: the next item is taken while
// a result still waits. When the receiver stalls, the block holds the result
// and pauses at the next point where it needs the output register.
// Reset empties the list at once; no clearing pass is needed.
// ============================================================================
module positional_list_engine #(
    parameter int CAPACITY = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [2:0]   opcode,
    input  wire logic [31:0]  item_value,
    input  wire logic [6:0]   item_position,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [2:0]        status,
    output logic [6:0]        found_position,
    output logic [31:0]       out_value,
    output logic              last
);
    import ple_pkg::*;

    // Commands from the sequencer and status back from the datapath.
    ple_cmd_t       cmd;
    ple_dp_status_t dp_st;

    ple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .dp_st    (dp_st),
        .cmd      (cmd)
    );

    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .dp_st          (dp_st),
        .opcode         (opcode),
        .item_value     (item_value),
        .item_position  (item_position),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .found_position (found_position),
        .out_value      (out_value),
        .last           (last)
    );

`ifndef NO_ASSERTIONS
    // The list never grows past its capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dp_st.count <= COUNT_W'(CAPACITY))
        else $error("list length exceeds capacity");

    // Only an applied insert or delete may change the list length.
    a_count_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.apply |=> $stable(dp_st.count))
        else $error("list length changed without an applied operation");

    // A result is only written into a free output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply || cmd.emit_elem || cmd.emit_search) |-> dp_st.out_free)
        else $error("result written over a pending transfer");

    // After an input transfer the block is busy and takes no input in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken in back-to-back cycles");
`endif

endmodule
`default_nettype wire

@@ src/ple_datapath.sv @@
`default_nettype none
// ============================================================================
// ple_datapath
// Row of element cells with shift, rotate and compare logic, the operation
// decoder, the scan counter and the result output register.
// ============================================================================
module ple_datapath #(
    parameter int CAPACITY = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ple_pkg::ple_cmd_t        cmd,
    output ple_pkg::ple_dp_status_t       dp_st,
    input  wire logic [2:0]               opcode,
    input  wire logic [31:0]              item_value,
    input  wire logic [6:0]               item_position,
    input  wire logic                     out_ready,
    output logic                          out_valid,
    output logic [2:0]                    status,
    output logic [6:0]                    found_position,
    output logic [31:0]                   out_value,
    output logic                          last
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Latched input item.
    ple_op_t              op_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [POS_W-1:0]     pos_reg;

    // Element cells and list length.
    logic [VALUE_W-1:0]   cell_reg  [CAPACITY];
    logic [VALUE_W-1:0]   cell_next [CAPACITY];
    logic [VALUE_W-1:0]   prev_val  [CAPACITY];
    logic [VALUE_W-1:0]   next_val  [CAPACITY];
    logic [CNT_W-1:0]     count_reg, count_next;

    // Scan state.
    logic [CNT_W-1:0]     k_reg;
    logic                 hit_reg;
    logic [POS_W-1:0]     found_reg;

    // Output register.
    logic                 out_valid_reg;
    ple_status_t          status_reg;
    logic [POS_W-1:0]     found_position_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic                 last_reg;

    // Decode.
    logic                 is_ins, is_scan_op, full, empty, mutate, scan_last, out_free;
    logic [CMP_W-1:0]     n8, p8, idx8;
    ple_status_t          simple_st;

    assign n8         = CMP_W'(count_reg);
    assign p8         = CMP_W'(pos_reg);
    assign is_ins     = op_reg inside {OP_INS_FRONT, OP_INS_BACK, OP_INS_AT};
    assign is_scan_op = op_reg inside {OP_SEARCH, OP_DUMP};
    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign scan_last  = ((k_reg + CNT_W'(1)) == count_reg);
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        case (op_reg)
            OP_INS_FRONT: idx8 = '0;
            OP_INS_BACK:  idx8 = n8;
            OP_INS_AT:    idx8 = p8 - CMP_W'(1);
            OP_DEL_FRONT: idx8 = '0;
            OP_DEL_BACK:  idx8 = n8 - CMP_W'(1);
            OP_DEL_AT:    idx8 = p8 - CMP_W'(1);
            default:      idx8 = '0;
        endcase

        if (is_ins)
        begin
            if (full)
                simple_st = ST_FULL;
            else if ((op_reg == OP_INS_AT) && ((p8 == '0) || (p8 > n8 + CMP_W'(1))))
                simple_st = ST_RANGE;
            else
                simple_st = ST_OK;
        end
        else
        begin
            if (empty)
                simple_st = ST_EMPTY;
            else if ((op_reg == OP_DEL_AT) && ((p8 == '0) || (p8 > n8)))
                simple_st = ST_RANGE;
            else
                simple_st = ST_OK;
        end

        mutate = (simple_st == ST_OK) && !is_scan_op;
    end

    // Fixed neighbor taps of each cell.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_tap
            if (g > 0)
            begin : g_prev
                assign prev_val[g] = cell_reg[g-1];
            end
            else
            begin : g_prev0
                assign prev_val[g] = cell_reg[g];
            end
            if (g < CAPACITY - 1)
            begin : g_next
                assign next_val[g] = cell_reg[g+1];
            end
            else
            begin : g_nextn
                assign next_val[g] = cell_reg[g];
            end
        end
    endgenerate

    // Each cell picks its own next value: insert shifts back, delete shifts
    // forward, a scan rotates the occupied cells by one toward the front.
    always_comb
    begin
        logic [CMP_W-1:0] i8;
        i8 = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            i8 = CMP_W'(i);
            cell_next[i] = cell_reg[i];
            if (cmd.apply && mutate)
            begin
                if (is_ins)
                begin
                    if (i8 == idx8)
                        cell_next[i] = val_reg;
                    else if ((i8 > idx8) && (i8 <= n8))
                        cell_next[i] = prev_val[i];
                end
                else if ((i8 >= idx8) && (i8 + CMP_W'(1) < n8))
                begin
                    cell_next[i] = next_val[i];
                end
            end
            else if (cmd.scan_step)
            begin
                if (i8 + CMP_W'(1) < n8)
                    cell_next[i] = next_val[i];
                else if (i8 + CMP_W'(1) == n8)
                    cell_next[i] = cell_reg[0];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.apply && mutate)
            count_next = is_ins ? count_reg + CNT_W'(1) : count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
            cell_reg[i] <= cell_next[i];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= ple_op_t'(opcode);
            val_reg <= item_value;
            pos_reg <= item_position;
        end
        if (cmd.scan_clr)
            k_reg <= '0;
        else if (cmd.scan_step)
            k_reg <= k_reg + CNT_W'(1);
        if (cmd.scan_step && !hit_reg && (cell_reg[0] == val_reg))
            found_reg <= POS_W'(k_reg) + POS_W'(1);
        if (cmd.apply)
        begin
            status_reg         <= simple_st;
            found_position_reg <= '0;
            out_value_reg      <= '0;
            last_reg           <= 1'b1;
        end
        else if (cmd.emit_elem)
        begin
            status_reg         <= ST_OK;
            found_position_reg <= '0;
            out_value_reg      <= cell_reg[0];
            last_reg           <= scan_last;
        end
        else if (cmd.emit_search)
        begin
            status_reg         <= hit_reg ? ST_OK : ST_NOTFOUND;
            found_position_reg <= hit_reg ? found_reg : '0;
            out_value_reg      <= hit_reg ? val_reg : '0;
            last_reg           <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.scan_clr)
                hit_reg <= 1'b0;
            else if (cmd.scan_step && (cell_reg[0] == val_reg))
                hit_reg <= 1'b1;
            if (cmd.apply || cmd.emit_elem || cmd.emit_search)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign dp_st.out_free    = out_free;
    assign dp_st.scan_needed = is_scan_op && !empty;
    assign dp_st.scan_last   = scan_last;
    assign dp_st.is_dump     = (op_reg == OP_DUMP);
    assign dp_st.count       = COUNT_W'(count_reg);

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_position = found_position_reg;
    assign out_value      = out_value_reg;
    assign last           = last_reg;

endmodule
`default_nettype wire

@@ src/ple_ctrl.sv @@
`default_nettype none
// ============================================================================
// ple_ctrl
// Sequencer for the positional list engine: takes an item, lets the datapath
// decide and apply it, and walks the list for searches and dumps.
// ============================================================================
module ple_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire ple_pkg::ple_dp_status_t  dp_st,
    output ple_pkg::ple_cmd_t             cmd
);
    import ple_pkg::*;

    ple_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (dp_st.scan_needed)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
                else if (dp_st.out_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // A dump hands out one element per transfer; a search runs freely.
                if (dp_st.is_dump)
                begin
                    if (dp_st.out_free)
                    begin
                        cmd.emit_elem = 1'b1;
                        cmd.scan_step = 1'b1;
                        if (dp_st.scan_last)
                            state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (dp_st.scan_last)
                        state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                if (dp_st.out_free)
                begin
                    cmd.emit_search = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the positional list engine. A shadow list is
// updated for every operation that transfers in, and each answer that
// transfers out is compared field by field with the oldest predicted answer.
// Stimulus is a short directed pass over the corner cases, followed by random
// fill, drain and mixed sequences. Both handshakes idle at random.
// ============================================================================
module tb;
    import ple_pkg::*;

    localparam int LIST_CAP     = 32;
    localparam int RANDOM_OPS   = 300;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = LIST_CAP + 16;
    localparam int MAX_PRINTED  = 100;

    typedef struct {
        ple_op_t           op;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } list_op_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  value;
        logic                last;
    } list_reply_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [VALUE_W-1:0]  item_value = '0;
    logic [POS_W-1:0]    item_position = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_position;
    logic [VALUE_W-1:0]  out_value;
    logic                last;

    positional_list_engine #(
        .CAPACITY(LIST_CAP)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .item_value     (item_value),
        .item_position  (item_position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .found_position (found_position),
        .out_value      (out_value),
        .last           (last)
    );

    // Operations still to be offered, and answers still owed by the block.
    list_op_t    pending_ops[$];
    list_reply_t expected_replies[$];

    // Shadow copy of the list as the block should hold it.
    logic [VALUE_W-1:0] model_cells [LIST_CAP];
    int                 model_count = 0;
    int                 model_peak  = 0;

    // The generator keeps its own view of the length so that it can steer
    // fills and drains, plus a few recent values to search for.
    int                 gen_count = 0;
    int                 random_ops_queued = 0;
    logic [VALUE_W-1:0] value_pool[$];

    int cycle_count   = 0;
    int error_count   = 0;
    int ops_accepted  = 0;
    int replies_seen  = 0;
    int status_hits [5] = '{default: 0};

    int in_gap    = 0;
    bit in_calm   = 1'b0;
    int out_stall = 0;
    bit out_calm  = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_error(string msg);
        if (error_count < MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int idle_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(10, 24);
    endfunction

    task automatic add_expected(ple_status_t st, logic [POS_W-1:0] pos,
                                logic [VALUE_W-1:0] val, logic fin);
        list_reply_t r;
        r.status   = st;
        r.position = pos;
        r.value    = val;
        r.last     = fin;
        expected_replies.push_back(r);
        status_hits[int'(st)]++;
    endtask

    // Applies one operation to the shadow list and queues the answers that
    // it must produce.
    task automatic predict_list_op(ple_op_t op, logic [VALUE_W-1:0] val,
                                   logic [POS_W-1:0] pos);
        int slot;
        int p;
        bit hit;
        p = int'(pos);
        case (op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT:
            begin
                // A full list refuses before the position is looked at.
                if (model_count >= LIST_CAP)
                    add_expected(ST_FULL, '0, '0, 1'b1);
                else if (op == OP_INS_AT && (p < 1 || p > model_count + 1))
                    add_expected(ST_RANGE, '0, '0, 1'b1);
                else
                begin
                    slot = (op == OP_INS_FRONT) ? 0 :
                           (op == OP_INS_BACK)  ? model_count : p - 1;
                    for (int i = model_count; i > slot; i--)
                        model_cells[i] = model_cells[i - 1];
                    model_cells[slot] = val;
                    model_count++;
                    if (model_count > model_peak)
                        model_peak = model_count;
                    add_expected(ST_OK, '0, '0, 1'b1);
                end
            end
            default:
            begin
                // An empty list answers before any position check.
                if (model_count == 0)
                    add_expected(ST_EMPTY, '0, '0, 1'b1);
                else if (op == OP_SEARCH)
                begin
                    hit = 1'b0;
                    for (int i = 0; i < model_count; i++)
                    begin
                        if (!hit && model_cells[i] == val)
                        begin
                            hit = 1'b1;
                            add_expected(ST_OK, POS_W'(i + 1), model_cells[i], 1'b1);
                        end
                    end
                    if (!hit)
                        add_expected(ST_NOTFOUND, '0, '0, 1'b1);
                end
                else if (op == OP_DUMP)
                begin
                    for (int i = 0; i < model_count; i++)
                        add_expected(ST_OK, '0, model_cells[i], i == model_count - 1);
                end
                else if (op == OP_DEL_AT && (p < 1 || p > model_count))
                    add_expected(ST_RANGE, '0, '0, 1'b1);
                else
                begin
                    slot = (op == OP_DEL_FRONT) ? 0 :
                           (op == OP_DEL_BACK)  ? model_count - 1 : p - 1;
                    for (int i = slot; i + 1 < model_count; i++)
                        model_cells[i] = model_cells[i + 1];
                    model_count--;
                    add_expected(ST_OK, '0, '0, 1'b1);
                end
            end
        endcase
    endtask

    // Queues one operation and tracks the length the list will have after it.
    task automatic queue_op(ple_op_t op, logic [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
        list_op_t item;
        int p;
        item.op       = op;
        item.value    = val;
        item.position = pos;
        pending_ops.push_back(item);
        p = int'(pos);
        if (op == OP_INS_FRONT || op == OP_INS_BACK || op == OP_INS_AT)
        begin
            if (gen_count < LIST_CAP && (op != OP_INS_AT || (p >= 1 && p <= gen_count + 1)))
            begin
                gen_count++;
                value_pool.push_back(val);
                if (value_pool.size() > 16)
                    void'(value_pool.pop_front());
            end
        end
        else if (op == OP_DEL_FRONT || op == OP_DEL_BACK || op == OP_DEL_AT)
        begin
            if (gen_count > 0 && (op != OP_DEL_AT || (p >= 1 && p <= gen_count)))
                gen_count--;
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(bit from_pool);
        if (from_pool && value_pool.size() > 0 && $urandom_range(0, 3) != 0)
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4, 5:    return VALUE_W'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // Mostly a legal position up to hi, sometimes just outside, sometimes
    // anything the field can hold.
    function automatic logic [POS_W-1:0] pick_position(int hi);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return POS_W'(hi + 1);
            2:       return POS_W'($urandom_range(0, 127));
            default: return (hi >= 1) ? POS_W'($urandom_range(1, hi)) : POS_W'(1);
        endcase
    endfunction

    task automatic add_random_op(ple_op_t op);
        logic [VALUE_W-1:0] val;
        logic [POS_W-1:0]   pos;
        val = (op == OP_SEARCH) ? pick_value(1'b1) : pick_value(1'b0);
        pos = POS_W'($urandom_range(0, 127));
        if (op == OP_INS_AT)
            pos = pick_position(gen_count + 1);
        else if (op == OP_DEL_AT)
            pos = pick_position(gen_count);
        queue_op(op, val, pos);
        random_ops_queued++;
    endtask

    // Driver: offers the next pending operation and keeps it steady until it
    // transfers. The shadow list is updated at the edge of each transfer.
    always @(posedge clk or negedge rst_n)
    begin : drive_ops
        list_op_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                in_calm = !in_calm;
            if (in_valid && in_ready)
            begin
                predict_list_op(ple_op_t'(opcode), item_value, item_position);
                ops_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    nxt = pending_ops.pop_front();
                    opcode        <= nxt.op;
                    item_value    <= nxt.value;
                    item_position <= nxt.position;
                    in_valid      <= 1'b1;
                    in_gap = idle_gap(in_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each answer that transfers out and throttles the
    // receiver side.
    always @(posedge clk or negedge rst_n)
    begin : check_replies
        list_reply_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                out_calm = !out_calm;
            if (out_valid && out_ready)
            begin
                replies_seen++;
                if (expected_replies.size() == 0)
                    report_error($sformatf("unexpected answer: status %0d pos %0d value %h last %b",
                                           status, found_position, out_value, last));
                else
                begin
                    want = expected_replies.pop_front();
                    if (status !== want.status)
                        report_error($sformatf("answer %0d status: got %0d, expected %0d",
                                               replies_seen, status, want.status));
                    if (found_position !== want.position)
                        report_error($sformatf("answer %0d position: got %0d, expected %0d",
                                               replies_seen, found_position, want.position));
                    if (out_value !== want.value)
                        report_error($sformatf("answer %0d value: got %h, expected %h",
                                               replies_seen, out_value, want.value));
                    if (last !== want.last)
                        report_error($sformatf("answer %0d last: got %b, expected %b",
                                               replies_seen, last, want.last));
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!out_calm && $urandom_range(0, 3) == 0)
                    out_stall = idle_gap(1'b0);
            end
        end
    end

    initial
    begin : run_test
        int kind;
        bit timed_out;
        rst_n = 1'b0;

        // Corner cases: every delete, search, dump and positional insert on an empty
        // list, position bounds on both sides, the value extremes, a duplicate so that
        // the search must report the first match, and a miss.
        queue_op(OP_DUMP,      32'h0000_0000, 7'd0);
        queue_op(OP_SEARCH,    32'h0000_0000, 7'd0);
        queue_op(OP_DEL_FRONT, 32'h0000_0000, 7'd0);
        queue_op(OP_DEL_BACK,  32'h0000_0000, 7'd0);
        queue_op(OP_DEL_AT,    32'h0000_0000, 7'd0);
        queue_op(OP_INS_AT,    32'h0000_0001, 7'd0);
        queue_op(OP_INS_AT,    32'h0000_0001, 7'd2);
        queue_op(OP_INS_AT,    32'h8000_0000, 7'd1);
        queue_op(OP_INS_FRONT, 32'h7fff_ffff, 7'd0);
        queue_op(OP_INS_BACK,  32'hffff_ffff, 7'd0);
        queue_op(OP_INS_AT,    32'h0000_0000, 7'd4);
        queue_op(OP_INS_AT,    32'hffff_ffff, 7'd2);
        queue_op(OP_SEARCH,    32'hffff_ffff, 7'd0);
        queue_op(OP_SEARCH,    32'h1234_5678, 7'd0);
        queue_op(OP_INS_AT,    32'h5555_5555, 7'd127);
        queue_op(OP_DUMP,      32'h0000_0000, 7'd0);
        queue_op(OP_DEL_AT,    32'h0000_0000, 7'd0);
        queue_op(OP_DEL_AT,    32'h0000_0000, 7'd6);
        queue_op(OP_DEL_AT,    32'h0000_0000, 7'd5);
        queue_op(OP_DEL_AT,    32'h0000_0000, 7'd1);
        queue_op(OP_DEL_FRONT, 32'h0000_0000, 7'd0);
        queue_op(OP_DEL_BACK,  32'h0000_0000, 7'd0);
        queue_op(OP_SEARCH,    32'h8000_0000, 7'd0);
        queue_op(OP_DEL_BACK,  32'h0000_0000, 7'd0);
        queue_op(OP_DUMP,      32'h0000_0000, 7'd0);

        // Random part: fills up to capacity and beyond, drains to empty, and
        // mixed traffic in between.
        while (random_ops_queued < RANDOM_OPS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 2)
            begin
                while (gen_count < LIST_CAP)
                    add_random_op(ple_op_t'($urandom_range(0, 2)));
                repeat ($urandom_range(1, 3))
                    add_random_op(ple_op_t'($urandom_range(0, 2)));
                add_random_op(OP_SEARCH);
                add_random_op(OP_DUMP);
            end
            else if (kind < 4)
            begin
                while (gen_count > 0)
                    add_random_op(ple_op_t'($urandom_range(3, 5)));
                add_random_op(ple_op_t'($urandom_range(3, 7)));
            end
            else
            begin
                repeat ($urandom_range(8, 20))
                begin
                    if (gen_count < 3 && $urandom_range(0, 1) == 0)
                        add_random_op(ple_op_t'($urandom_range(0, 2)));
                    else
                        add_random_op(ple_op_t'($urandom_range(0, 7)));
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Checked on the falling edge so that the driver and the monitor have
        // settled for the cycle.
        timed_out = 1'b0;
        while (pending_ops.size() != 0 || in_valid || expected_replies.size() != 0)
        begin
            @(negedge clk);
            if (cycle_count >= CYCLE_LIMIT)
            begin
                timed_out = 1'b1;
                break;
            end
        end

        if (timed_out)
        begin
            $display("Timeout after %0d cycles with %0d answers outstanding",
                     cycle_count, expected_replies.size());
            $display("TEST FAILED");
        end
        else
        begin
            // Give a stray extra answer a chance to show up.
            repeat (DRAIN_CYCLES) @(negedge clk);
            $display("Ran %0d operations and checked %0d answers in %0d cycles; %0d errors.",
                     ops_accepted, replies_seen, cycle_count, error_count);
            $display("List peaked at %0d of %0d; ok %0d, empty %0d, range %0d, miss %0d, full %0d.",
                     model_peak, LIST_CAP, status_hits[0], status_hits[1],
                     status_hits[2], status_hits[3], status_hits[4]);
            if (error_count == 0)
                $display("TEST PASSED");
            else
                $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/ple_pkg.sv
src/ple_datapath.sv
src/ple_ctrl.sv
src/positional_list_engine.sv
dv/tb.sv
